// File: rtl/assert_macros.svh
// Assertion macros used by the framer RTL.
// Files that check their own logic include this header; it needs clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSUCF_ASSERT_SAME(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("framer check failed");

// The consequent must hold in the cycle after the antecedent.
`define PSUCF_ASSERT_NEXT(name, pre, post) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("framer check failed");

`endif

// File: rtl/psucf_pkg.sv
// Shared types, constants, microcode program and frame byte table of the command framer.
// Has no dependencies; every RTL module imports it.
package psucf_pkg;

  localparam int unsigned FRAME_LENGTH = 26;
  localparam int unsigned IdxW         = $clog2(FRAME_LENGTH);
  localparam logic [IdxW-1:0] CHECKSUM_IDX = IdxW'(FRAME_LENGTH - 1);

  localparam logic [7:0] SYNC_BYTE       = 8'hAA;
  localparam logic [7:0] CMD_SET_PARAMS  = 8'h80;
  localparam logic [7:0] CMD_CTRL_MODE   = 8'h82;
  localparam logic [7:0] MODE_PC_ON      = 8'h03;
  localparam logic [7:0] MODE_PC_OFF     = 8'h02;
  localparam logic [7:0] MODE_SELF       = 8'h00;
  localparam logic [31:0] TICK_INCREMENT = 32'd1000;

  localparam int unsigned DivSteps = 32;
  localparam int unsigned CntW     = $clog2(DivSteps);
  localparam logic [CntW-1:0] DIV_LAST = CntW'(DivSteps - 1);

  // Operation codes of the input beat.
  localparam logic [2:0] OP_TICK       = 3'd0;
  localparam logic [2:0] OP_SET_PARAMS = 3'd1;
  localparam logic [2:0] OP_PC_ON      = 3'd2;
  localparam logic [2:0] OP_PC_OFF     = 3'd3;
  localparam logic [2:0] OP_SELF       = 3'd4;

  // Register indexes of the configuration port.
  localparam int unsigned RegIdxW = 3;
  localparam logic [RegIdxW-1:0] REG_DEVICE_ADDRESS = 3'd0;
  localparam logic [RegIdxW-1:0] REG_CURRENT_LIMIT  = 3'd1;
  localparam logic [RegIdxW-1:0] REG_VOLTAGE_LIMIT  = 3'd2;
  localparam logic [RegIdxW-1:0] REG_POWER_LIMIT    = 3'd3;
  localparam logic [RegIdxW-1:0] REG_UPDATE_PERIOD  = 3'd4;
  localparam logic [RegIdxW-1:0] REG_PERIODIC_EN    = 3'd5;
  localparam logic [RegIdxW-1:0] REG_SAMPLE_MIN     = 3'd6;
  localparam logic [RegIdxW-1:0] REG_SAMPLE_MAX     = 3'd7;

  // Sequencer step addresses.
  localparam int unsigned StepW = 4;
  localparam logic [StepW-1:0] STEP_FETCH  = 4'd0;
  localparam logic [StepW-1:0] STEP_TICK   = 4'd1;
  localparam logic [StepW-1:0] STEP_MUL    = 4'd2;
  localparam logic [StepW-1:0] STEP_DIV    = 4'd3;
  localparam logic [StepW-1:0] STEP_SAT    = 4'd4;
  localparam logic [StepW-1:0] STEP_EMIT   = 4'd5;
  localparam logic [StepW-1:0] STEP_DONE   = 4'd6;
  localparam logic [StepW-1:0] STEP_LD_MAN = 4'd7;
  localparam logic [StepW-1:0] STEP_LD_MOD = 4'd8;

  typedef enum logic [3:0] {
    ACT_FETCH,
    ACT_TICK,
    ACT_MUL,
    ACT_DIV,
    ACT_SAT,
    ACT_EMIT,
    ACT_NOP,
    ACT_LD_MAN,
    ACT_LD_MOD
  } psucf_act_e;

  typedef enum logic [2:0] {
    JC_NONE,
    JC_ALWAYS,
    JC_DISPATCH,
    JC_NOFRAME,
    JC_LOOP,
    JC_MORE
  } psucf_jc_e;

  typedef struct packed {
    psucf_act_e       act;
    psucf_jc_e        jc;
    logic [StepW-1:0] target;
  } psucf_uword_t;

  typedef struct packed {
    logic [2:0]         operation;
    logic signed [15:0] sample;
    logic [15:0]        manual_voltage;
  } psucf_in_t;

  typedef struct packed {
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [15:0] voltage_sent;
  } psucf_out_t;

  typedef struct packed {
    logic [7:0]         device_address;
    logic [15:0]        current_limit;
    logic [15:0]        voltage_limit;
    logic [15:0]        power_limit;
    logic [15:0]        update_period_ms;
    logic               periodic_enable;
    logic signed [15:0] sample_min;
    logic signed [15:0] sample_max;
  } psucf_cfg_t;

  // Control program: go to target if the jump condition holds, else next step; dispatch by op.
  function automatic psucf_uword_t psucf_rom(input logic [StepW-1:0] step);
    psucf_uword_t w;
    w = '{act: ACT_NOP, jc: JC_ALWAYS, target: STEP_FETCH};
    case (step)
      STEP_FETCH:  w = '{act: ACT_FETCH,  jc: JC_DISPATCH, target: STEP_FETCH};
      STEP_TICK:   w = '{act: ACT_TICK,   jc: JC_NOFRAME,  target: STEP_FETCH};
      STEP_MUL:    w = '{act: ACT_MUL,    jc: JC_NONE,     target: STEP_FETCH};
      STEP_DIV:    w = '{act: ACT_DIV,    jc: JC_LOOP,     target: STEP_DIV};
      STEP_SAT:    w = '{act: ACT_SAT,    jc: JC_NONE,     target: STEP_FETCH};
      STEP_EMIT:   w = '{act: ACT_EMIT,   jc: JC_MORE,     target: STEP_EMIT};
      STEP_DONE:   w = '{act: ACT_NOP,    jc: JC_ALWAYS,   target: STEP_FETCH};
      STEP_LD_MAN: w = '{act: ACT_LD_MAN, jc: JC_ALWAYS,   target: STEP_EMIT};
      STEP_LD_MOD: w = '{act: ACT_LD_MOD, jc: JC_ALWAYS,   target: STEP_EMIT};
      default:     w = '{act: ACT_NOP,    jc: JC_ALWAYS,   target: STEP_FETCH};
    endcase
    return w;
  endfunction

  // Entry step for each operation code; unused codes return straight to fetch.
  function automatic logic [StepW-1:0] psucf_dispatch(input logic [2:0] op);
    logic [StepW-1:0] s;
    case (op)
      OP_TICK:       s = STEP_TICK;
      OP_SET_PARAMS: s = STEP_LD_MAN;
      OP_PC_ON:      s = STEP_LD_MOD;
      OP_PC_OFF:     s = STEP_LD_MOD;
      OP_SELF:       s = STEP_LD_MOD;
      default:       s = STEP_FETCH;
    endcase
    return s;
  endfunction

  function automatic logic [7:0] psucf_mode_byte(input logic [2:0] op);
    logic [7:0] m;
    case (op)
      OP_PC_ON:  m = MODE_PC_ON;
      OP_PC_OFF: m = MODE_PC_OFF;
      default:   m = MODE_SELF;
    endcase
    return m;
  endfunction

  // Frame bytes before the checksum, selected by position.
  function automatic logic [7:0] psucf_frame_byte(input logic [IdxW-1:0] idx,
                                                  input logic            is_param,
                                                  input psucf_cfg_t      cfg,
                                                  input logic [15:0]     volt,
                                                  input logic [7:0]      mode);
    logic [7:0] b;
    case (idx)
      5'd0:    b = SYNC_BYTE;
      5'd1:    b = is_param ? cfg.device_address : 8'h00;
      5'd2:    b = is_param ? CMD_SET_PARAMS : CMD_CTRL_MODE;
      5'd3:    b = is_param ? cfg.current_limit[7:0] : mode;
      5'd4:    b = is_param ? cfg.current_limit[15:8] : 8'h00;
      5'd5:    b = is_param ? cfg.voltage_limit[7:0] : 8'h00;
      5'd6:    b = is_param ? cfg.voltage_limit[15:8] : 8'h00;
      5'd9:    b = is_param ? cfg.power_limit[7:0] : 8'h00;
      5'd10:   b = is_param ? cfg.power_limit[15:8] : 8'h00;
      5'd11:   b = is_param ? volt[7:0] : 8'h00;
      5'd12:   b = is_param ? volt[15:8] : 8'h00;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/psucf_cfg_regs.sv
// Configuration register file of the command framer, written and read over an APB-style port.
// Depends on psucf_pkg for the register indexes and the configuration struct.
module psucf_cfg_regs import psucf_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output psucf_cfg_t  cfg_o
);

  psucf_cfg_t           cfg_q, cfg_d;
  logic                 wr_en;
  logic [RegIdxW-1:0]   reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite;
  assign reg_idx = paddr[4:2];
  assign cfg_o   = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (reg_idx)
        REG_DEVICE_ADDRESS: cfg_d.device_address   = pwdata[7:0];
        REG_CURRENT_LIMIT:  cfg_d.current_limit    = pwdata[15:0];
        REG_VOLTAGE_LIMIT:  cfg_d.voltage_limit    = pwdata[15:0];
        REG_POWER_LIMIT:    cfg_d.power_limit      = pwdata[15:0];
        REG_UPDATE_PERIOD:  cfg_d.update_period_ms = pwdata[15:0];
        REG_PERIODIC_EN:    cfg_d.periodic_enable  = pwdata[0];
        REG_SAMPLE_MIN:     cfg_d.sample_min       = pwdata[15:0];
        REG_SAMPLE_MAX:     cfg_d.sample_max       = pwdata[15:0];
        default:            cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_DEVICE_ADDRESS: prdata = {24'h0, cfg_q.device_address};
      REG_CURRENT_LIMIT:  prdata = {16'h0, cfg_q.current_limit};
      REG_VOLTAGE_LIMIT:  prdata = {16'h0, cfg_q.voltage_limit};
      REG_POWER_LIMIT:    prdata = {16'h0, cfg_q.power_limit};
      REG_UPDATE_PERIOD:  prdata = {16'h0, cfg_q.update_period_ms};
      REG_PERIODIC_EN:    prdata = {31'h0, cfg_q.periodic_enable};
      REG_SAMPLE_MIN:     prdata = {16'h0, cfg_q.sample_min};
      REG_SAMPLE_MAX:     prdata = {16'h0, cfg_q.sample_max};
      default:            prdata = 32'h0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address   <= 8'd1;
      cfg_q.current_limit    <= 16'd150;
      cfg_q.voltage_limit    <= 16'd10000;
      cfg_q.power_limit      <= 16'd10000;
      cfg_q.update_period_ms <= 16'd50;
      cfg_q.periodic_enable  <= 1'b0;
      cfg_q.sample_min       <= 16'sd0;
      cfg_q.sample_max       <= 16'sd1000;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// File: rtl/psu_command_framer_top.sv
// Top level of the power supply command framer: microcoded sequencer, scaling datapath, output stage.
// Depends on psucf_pkg, psucf_cfg_regs and assert_macros.svh.
//
//   Channel   Handshake              Payload / signals             Direction
//   input     in_valid_i/in_ready_o  in_data_i (psucf_in_t)        into block
//   output    out_valid_o/out_ready_i out_data_o (psucf_out_t)     out of block
//   config    psel/penable/pwrite    paddr, pwdata, prdata, pready APB-style, 32-bit data
//
// Steps: one beat is taken in the fetch step. A frame then sends one byte per cycle when the
// output side keeps up, 26 bytes, plus one load step and one closing step. A periodic frame
// adds the tick step, the multiply step and 32 steps of the one-bit-per-cycle divider.
// A tick that sends nothing runs only the tick step after the fetch.
// Reset clears the sequencer, the tick accumulator, the byte counter and the output valid flag.
// A stall on the output holds the emit step; the input is taken only in the fetch step.
`include "assert_macros.svh"

module psu_command_framer_top import psucf_pkg::*; #(
  parameter int unsigned PACKET_RATE = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  psucf_in_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output psucf_out_t  out_data_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  psucf_cfg_t cfg;

  psucf_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // Sequencer: the step counter addresses the control program in the package.
  logic [StepW-1:0] pc_q, pc_d;
  psucf_uword_t     uw;
  logic             advance;
  logic             jump_taken;

  // Control state (reset) and payload registers (no reset).
  logic [31:0]      acc_q, acc_d;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             out_valid_q, out_valid_d;
  psucf_out_t       out_q, out_d;
  logic [2:0]       op_q, op_d;
  logic signed [15:0] sample_q, sample_d;
  logic [15:0]      manual_q, manual_d;
  logic [31:0]      quot_q, quot_d;
  logic [15:0]      rem_q, rem_d;
  logic [15:0]      den_mag_q, den_mag_d;
  logic             neg_q, neg_d;
  logic             den_zero_q, den_zero_d;
  logic [15:0]      volt_q, volt_d;
  logic             is_param_q, is_param_d;
  logic [7:0]       mode_q, mode_d;
  logic [7:0]       sum_q, sum_d;

  // Tick arithmetic: the accumulator counts in 1/PACKET_RATE ms, so the threshold is exact.
  logic [32:0] acc_sum;
  logic [31:0] acc_sat;
  logic [31:0] thr;
  logic        below_thr;
  logic        no_frame;

  assign acc_sum   = {1'b0, acc_q} + {1'b0, TICK_INCREMENT};
  assign acc_sat   = acc_sum[32] ? 32'hFFFF_FFFF : acc_sum[31:0];
  assign thr       = 32'(cfg.update_period_ms) * 32'(PACKET_RATE);
  assign below_thr = acc_sat < thr;
  assign no_frame  = !cfg.periodic_enable || below_thr;

  // Scaling operands: magnitudes and signs, so the divider works on unsigned values.
  logic signed [16:0] diff, den;
  logic        [16:0] diff_abs, den_abs;

  assign diff     = 17'(sample_q) - 17'(cfg.sample_min);
  assign den      = 17'(cfg.sample_max) - 17'(cfg.sample_min);
  assign diff_abs = diff[16] ? 17'(-diff) : 17'(diff);
  assign den_abs  = den[16] ? 17'(-den) : 17'(den);

  // One restoring division step per cycle.
  logic [16:0] div_shift;
  logic        div_fit;
  logic [16:0] div_sub;

  assign div_shift = {rem_q, quot_q[31]};
  assign div_fit   = div_shift >= {1'b0, den_mag_q};
  assign div_sub   = div_shift - {1'b0, den_mag_q};

  // Output stage: a new byte may enter when the register is empty or being drained.
  logic       slot_free;
  logic       is_last;
  logic [7:0] cur_byte;

  assign slot_free = !out_valid_q || out_ready_i;
  assign is_last   = idx_q == CHECKSUM_IDX;
  assign cur_byte  = is_last ? sum_q
                             : psucf_frame_byte(idx_q, is_param_q, cfg, volt_q, mode_q);

  assign in_ready_o  = uw.act == ACT_FETCH;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // Next step.
  always_comb begin
    uw = psucf_rom(pc_q);
    case (uw.act)
      ACT_FETCH: advance = in_valid_i;
      ACT_EMIT:  advance = slot_free;
      default:   advance = 1'b1;
    endcase
    case (uw.jc)
      JC_ALWAYS:  jump_taken = 1'b1;
      JC_NOFRAME: jump_taken = no_frame;
      JC_LOOP:    jump_taken = cnt_q != '0;
      JC_MORE:    jump_taken = !is_last;
      default:    jump_taken = 1'b0;
    endcase
    if (!advance) begin
      pc_d = pc_q;
    end else if (uw.jc == JC_DISPATCH) begin
      pc_d = psucf_dispatch(in_data_i.operation);
    end else if (jump_taken) begin
      pc_d = uw.target;
    end else begin
      pc_d = pc_q + 1'b1;
    end
  end

  // Datapath, steered by the action field of the current control word.
  always_comb begin
    acc_d       = acc_q;
    idx_d       = idx_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    op_d        = op_q;
    sample_d    = sample_q;
    manual_d    = manual_q;
    quot_d      = quot_q;
    rem_d       = rem_q;
    den_mag_d   = den_mag_q;
    neg_d       = neg_q;
    den_zero_d  = den_zero_q;
    volt_d      = volt_q;
    is_param_d  = is_param_q;
    mode_d      = mode_q;
    sum_d       = sum_q;
    case (uw.act)
      ACT_FETCH: begin
        if (in_valid_i) begin
          op_d     = in_data_i.operation;
          sample_d = in_data_i.sample;
          manual_d = in_data_i.manual_voltage;
        end
      end
      ACT_TICK: begin
        // With periodic mode off the accumulator holds.
        if (cfg.periodic_enable) begin
          acc_d = below_thr ? acc_sat : acc_sat - thr;
        end
      end
      ACT_MUL: begin
        quot_d     = diff_abs[15:0] * cfg.voltage_limit;
        rem_d      = '0;
        den_mag_d  = den_abs[15:0];
        neg_d      = diff[16] ^ den[16];
        den_zero_d = den == '0;
        cnt_d      = DIV_LAST;
      end
      ACT_DIV: begin
        rem_d  = div_fit ? div_sub[15:0] : div_shift[15:0];
        quot_d = {quot_q[30:0], div_fit};
        cnt_d  = cnt_q - 1'b1;
      end
      ACT_SAT: begin
        // Equal bounds and negative quotients give zero; large ones clip at full scale.
        if (den_zero_q || neg_q) begin
          volt_d = '0;
        end else if (quot_q[31:16] != '0) begin
          volt_d = 16'hFFFF;
        end else begin
          volt_d = quot_q[15:0];
        end
        is_param_d = 1'b1;
        idx_d      = '0;
        sum_d      = '0;
      end
      ACT_LD_MAN: begin
        volt_d     = manual_q;
        is_param_d = 1'b1;
        idx_d      = '0;
        sum_d      = '0;
      end
      ACT_LD_MOD: begin
        volt_d     = '0;
        is_param_d = 1'b0;
        mode_d     = psucf_mode_byte(op_q);
        idx_d      = '0;
        sum_d      = '0;
      end
      ACT_EMIT: begin
        if (slot_free) begin
          out_valid_d        = 1'b1;
          out_d.frame_byte   = cur_byte;
          out_d.last_byte    = is_last;
          out_d.voltage_sent = volt_q;
          sum_d              = sum_q + cur_byte;
          idx_d              = is_last ? '0 : idx_q + 1'b1;
        end
      end
      default: begin
        acc_d = acc_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q        <= STEP_FETCH;
      acc_q       <= '0;
      idx_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pc_q        <= pc_d;
      acc_q       <= acc_d;
      idx_q       <= idx_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q      <= out_d;
    op_q       <= op_d;
    sample_q   <= sample_d;
    manual_q   <= manual_d;
    quot_q     <= quot_d;
    rem_q      <= rem_d;
    den_mag_q  <= den_mag_d;
    neg_q      <= neg_d;
    den_zero_q <= den_zero_d;
    volt_q     <= volt_d;
    is_param_q <= is_param_d;
    mode_q     <= mode_d;
    sum_q      <= sum_d;
  end

  // A new beat is only taken when no frame is half sent.
  `PSUCF_ASSERT_SAME(a_fetch_frame_idle, in_ready_o, idx_q == '0)
  // The checksum beat closes the frame and the program leaves the emit loop.
  `PSUCF_ASSERT_NEXT(a_last_ends_emit, (uw.act == ACT_EMIT) && slot_free && is_last,
                     pc_q == STEP_DONE)
  // The divider always starts with a full count after the multiply.
  `PSUCF_ASSERT_NEXT(a_div_start, pc_q == STEP_MUL, (pc_q == STEP_DIV) && (cnt_q == DIV_LAST))
  // Mode frames never carry a voltage.
  `PSUCF_ASSERT_SAME(a_mode_no_volt, (uw.act == ACT_EMIT) && !is_param_q, volt_q == '0)

endmodule

// File: verif/psucf_frame_checker.sv
// Frame checker for the power supply command framer: predicts every frame byte from the
// accepted input beats and the register writes it sees, and compares the output beats in order.
// Depends on psucf_pkg for the payload types, operation codes and register indexes.
`timescale 1ns / 1ps

module psucf_frame_checker import psucf_pkg::*; #(
  parameter int unsigned PacketRate = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  psucf_in_t   in_data_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  psucf_out_t  out_data_i,
  input  logic        psel_i,
  input  logic        penable_i,
  input  logic        pwrite_i,
  input  logic [4:0]  paddr_i,
  input  logic [31:0] pwdata_i,
  input  logic        pready_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned beats_in_o,
  output int unsigned beats_out_o
);

  localparam psucf_cfg_t CfgAtReset = '{
    device_address:   8'd1,
    current_limit:    16'd150,
    voltage_limit:    16'd10000,
    power_limit:      16'd10000,
    update_period_ms: 16'd50,
    periodic_enable:  1'b0,
    sample_min:       16'sd0,
    sample_max:       16'sd1000
  };

  psucf_cfg_t  shadow_cfg;
  logic [31:0] tick_acc;
  psucf_out_t  expected_bytes[$];
  int unsigned n_fail;
  int unsigned n_in;
  int unsigned n_out;

  // Exact integer scaling, truncated toward zero, then clamped to 0..65535.
  function automatic logic [15:0] scale_sample(input logic signed [15:0] s);
    longint lo;
    longint hi;
    longint den;
    longint num;
    longint q;
    lo  = shadow_cfg.sample_min;
    hi  = shadow_cfg.sample_max;
    den = hi - lo;
    if (den == 0) return 16'd0;
    num = (longint'(s) - lo) * longint'(shadow_cfg.voltage_limit);
    q   = num / den;
    if (q < 0) return 16'd0;
    if (q > 65535) return 16'hFFFF;
    return q[15:0];
  endfunction

  function automatic void queue_frame(input logic is_param, input logic [15:0] volt,
                                      input logic [7:0] mode);
    logic [7:0] fb [FRAME_LENGTH];
    logic [7:0] sum;
    psucf_out_t beat;
    foreach (fb[k]) fb[k] = 8'h00;
    fb[0] = SYNC_BYTE;
    if (is_param) begin
      fb[1]  = shadow_cfg.device_address;
      fb[2]  = CMD_SET_PARAMS;
      fb[3]  = shadow_cfg.current_limit[7:0];
      fb[4]  = shadow_cfg.current_limit[15:8];
      fb[5]  = shadow_cfg.voltage_limit[7:0];
      fb[6]  = shadow_cfg.voltage_limit[15:8];
      fb[9]  = shadow_cfg.power_limit[7:0];
      fb[10] = shadow_cfg.power_limit[15:8];
      fb[11] = volt[7:0];
      fb[12] = volt[15:8];
    end else begin
      fb[2] = CMD_CTRL_MODE;
      fb[3] = mode;
    end
    sum = 8'h00;
    for (int k = 0; k < FRAME_LENGTH - 1; k++) sum += fb[k];
    fb[FRAME_LENGTH-1] = sum;
    for (int k = 0; k < FRAME_LENGTH; k++) begin
      beat.frame_byte   = fb[k];
      beat.last_byte    = (k == FRAME_LENGTH - 1);
      beat.voltage_sent = is_param ? volt : 16'd0;
      expected_bytes.push_back(beat);
    end
  endfunction

  function automatic void predict_beat(input psucf_in_t it);
    logic [32:0] acc;
    logic [32:0] thr;
    case (it.operation)
      OP_TICK: begin
        if (shadow_cfg.periodic_enable) begin
          acc = {1'b0, tick_acc} + {1'b0, TICK_INCREMENT};
          if (acc[32]) acc = {1'b0, 32'hFFFF_FFFF};
          thr = 33'(shadow_cfg.update_period_ms) * 33'(PacketRate);
          if (acc < thr) begin
            tick_acc = acc[31:0];
          end else begin
            tick_acc = 32'(acc - thr);
            queue_frame(1'b1, scale_sample(it.sample), MODE_SELF);
          end
        end
      end
      OP_SET_PARAMS: queue_frame(1'b1, it.manual_voltage, MODE_SELF);
      OP_PC_ON:      queue_frame(1'b0, 16'd0, MODE_PC_ON);
      OP_PC_OFF:     queue_frame(1'b0, 16'd0, MODE_PC_OFF);
      OP_SELF:       queue_frame(1'b0, 16'd0, MODE_SELF);
      default: ;
    endcase
  endfunction

  function automatic void apply_write(input logic [RegIdxW-1:0] idx, input logic [31:0] d);
    case (idx)
      REG_DEVICE_ADDRESS: shadow_cfg.device_address   = d[7:0];
      REG_CURRENT_LIMIT:  shadow_cfg.current_limit    = d[15:0];
      REG_VOLTAGE_LIMIT:  shadow_cfg.voltage_limit    = d[15:0];
      REG_POWER_LIMIT:    shadow_cfg.power_limit      = d[15:0];
      REG_UPDATE_PERIOD:  shadow_cfg.update_period_ms = d[15:0];
      REG_PERIODIC_EN:    shadow_cfg.periodic_enable  = d[0];
      REG_SAMPLE_MIN:     shadow_cfg.sample_min       = d[15:0];
      REG_SAMPLE_MAX:     shadow_cfg.sample_max       = d[15:0];
      default: ;
    endcase
  endfunction

  function automatic void check_beat(input psucf_out_t got);
    psucf_out_t want;
    if (expected_bytes.size() == 0) begin
      n_fail++;
      if (n_fail <= 10)
        $display("output beat %0d not expected: byte %02h last %0b voltage %0d",
                 n_out, got.frame_byte, got.last_byte, got.voltage_sent);
      return;
    end
    want = expected_bytes.pop_front();
    if (got.frame_byte !== want.frame_byte || got.last_byte !== want.last_byte ||
        got.voltage_sent !== want.voltage_sent) begin
      n_fail++;
      if (n_fail <= 10)
        $display("output beat %0d: expected byte %02h last %0b voltage %0d, got %02h %0b %0d",
                 n_out, want.frame_byte, want.last_byte, want.voltage_sent,
                 got.frame_byte, got.last_byte, got.voltage_sent);
    end
  endfunction

  // Outputs are checked before inputs are predicted; the bytes of a beat accepted at this
  // edge cannot leave the block at the same edge.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_cfg = CfgAtReset;
      tick_acc   = 32'd0;
      expected_bytes.delete();
      n_fail     = 0;
      n_in       = 0;
      n_out      = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        check_beat(out_data_i);
        n_out++;
      end
      if (in_valid_i && in_ready_i) begin
        predict_beat(in_data_i);
        n_in++;
      end
      if (psel_i && penable_i && pwrite_i && pready_i) apply_write(paddr_i[4:2], pwdata_i);
    end
    fail_count_o <= n_fail;
    pending_o    <= expected_bytes.size();
    beats_in_o   <= n_in;
    beats_out_o  <= n_out;
  end

endmodule

// File: verif/tb_psu_command_framer_top.sv
// Testbench top for the power supply command framer: clock, reset, register writes, input
// stimulus, output back-pressure, watchdog and verdict. Prediction lives in psucf_frame_checker.
// Depends on psucf_pkg, psu_command_framer_top and psucf_frame_checker.
`timescale 1ns / 1ps

module tb_psu_command_framer_top;
  import psucf_pkg::*;

  localparam int unsigned PacketRate = 256;
  // The closing step after the last byte and a silent tick are short, so this settle time
  // covers any trailing activity.
  localparam int unsigned SettleCycles = 80;
  // Longest stretch with no beat on any channel in a correct run is the long receiver hold
  // plus a settle time; the watchdog allows many times that.
  localparam int unsigned HoldCycles   = 400;
  localparam int unsigned StallLimit   = 4000;
  localparam int unsigned RandomPhases = 6;
  localparam int unsigned BeatsPerPhase = 22;
  // Operation codes the block treats as no-ops.
  localparam logic [2:0] OP_UNUSED_FIRST = 3'd5;
  localparam logic [2:0] OP_UNUSED_LAST  = 3'd7;

  localparam psucf_cfg_t CfgAtReset = '{
    device_address:   8'd1,
    current_limit:    16'd150,
    voltage_limit:    16'd10000,
    power_limit:      16'd10000,
    update_period_ms: 16'd50,
    periodic_enable:  1'b0,
    sample_min:       16'sd0,
    sample_max:       16'sd1000
  };

  logic        clk_i;
  logic        rst_ni    = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_ready;
  psucf_in_t   in_data   = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  psucf_out_t  out_data;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [4:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned beats_in;
  int unsigned beats_out;

  // Stimulus knobs shared with the receiver process. quiet turns all idling off for the last
  // part of the run; hold_req asks the receiver for one long hold-off, which it clears itself.
  bit          quiet    = 1'b0;
  bit          hold_req = 1'b0;
  psucf_cfg_t  cur_cfg  = CfgAtReset;

  psu_command_framer_top #(.PACKET_RATE(PacketRate)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  psucf_frame_checker #(.PacketRate(PacketRate)) u_frame_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .out_data_i   (out_data),
    .psel_i       (psel),
    .penable_i    (penable),
    .pwrite_i     (pwrite),
    .paddr_i      (paddr),
    .pwdata_i     (pwdata),
    .pready_i     (pready),
    .fail_count_o (fail_count),
    .pending_o    (pending),
    .beats_in_o   (beats_in),
    .beats_out_o  (beats_out)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  // One register write: setup phase, access phase, then an idle phase with the bus released so
  // that back-to-back writes never drive psel twice in the same step.
  task automatic apb_write(input logic [RegIdxW-1:0] idx, input logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic load_config(input psucf_cfg_t c);
    apb_write(REG_DEVICE_ADDRESS, 32'(c.device_address));
    apb_write(REG_CURRENT_LIMIT,  32'(c.current_limit));
    apb_write(REG_VOLTAGE_LIMIT,  32'(c.voltage_limit));
    apb_write(REG_POWER_LIMIT,    32'(c.power_limit));
    apb_write(REG_UPDATE_PERIOD,  32'(c.update_period_ms));
    apb_write(REG_PERIODIC_EN,    {31'd0, c.periodic_enable});
    apb_write(REG_SAMPLE_MIN,     {16'h0000, c.sample_min});
    apb_write(REG_SAMPLE_MAX,     {16'h0000, c.sample_max});
    cur_cfg = c;
  endtask

  // Offers one input beat and returns at the edge that accepts it. valid is left high; the
  // next call either keeps it high with a new payload or opens a gap, and wait_drained lowers
  // it when the stream stops.
  task automatic send_beat(input psucf_in_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
  endtask

  // Stops offering beats and waits until every predicted frame byte has been seen. The
  // checker's pending count is registered, so the task waits for a clock edge before trusting it.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  function automatic psucf_in_t make_beat(input logic [2:0] op, input logic signed [15:0] s,
                                          input logic [15:0] mv);
    psucf_in_t it;
    it.operation      = op;
    it.sample         = s;
    it.manual_voltage = mv;
    return it;
  endfunction

  function automatic logic [15:0] pick_unsigned();
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return 16'h0000;
    if (r == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  function automatic logic signed [15:0] pick_signed();
    int unsigned r;
    r = $urandom_range(0, 3);
    if (r == 0) return 16'sh8000;
    if (r == 1) return 16'sh7FFF;
    return 16'($urandom);
  endfunction

  // Random settings: limits often at their extremes, short update periods so that ticks
  // actually produce frames, bounds sometimes equal and sometimes reversed.
  function automatic psucf_cfg_t random_config();
    psucf_cfg_t c;
    c.device_address   = 8'($urandom);
    c.current_limit    = pick_unsigned();
    c.voltage_limit    = pick_unsigned();
    c.power_limit      = pick_unsigned();
    c.update_period_ms = ($urandom_range(0, 7) == 0) ? pick_unsigned()
                                                    : 16'($urandom_range(0, 12));
    c.periodic_enable  = ($urandom_range(0, 3) != 0);
    c.sample_min       = pick_signed();
    c.sample_max       = pick_signed();
    if ($urandom_range(0, 7) == 0) c.sample_max = c.sample_min;
    return c;
  endfunction

  // Ticks dominate so the periodic path gets exercised; half the samples fall between the
  // configured bounds so that scaled voltages are not always clamped.
  function automatic psucf_in_t random_beat();
    psucf_in_t   it;
    int unsigned r;
    int          lo;
    int          hi;
    r = $urandom_range(0, 99);
    if (r < 40)      it.operation = OP_TICK;
    else if (r < 60) it.operation = OP_SET_PARAMS;
    else if (r < 70) it.operation = OP_PC_ON;
    else if (r < 80) it.operation = OP_PC_OFF;
    else if (r < 90) it.operation = OP_SELF;
    else             it.operation = 3'($urandom_range(OP_UNUSED_FIRST, OP_UNUSED_LAST));
    it.manual_voltage = 16'($urandom);
    if ($urandom_range(0, 1) == 0) begin
      it.sample = 16'($urandom);
    end else begin
      lo = (cur_cfg.sample_min < cur_cfg.sample_max) ? cur_cfg.sample_min : cur_cfg.sample_max;
      hi = (cur_cfg.sample_min < cur_cfg.sample_max) ? cur_cfg.sample_max : cur_cfg.sample_min;
      it.sample = 16'(lo + int'($urandom_range(0, hi - lo)));
    end
    return it;
  endfunction

  // Output side: bursts of ready low, longer stretches of ready high, and one long hold-off
  // on request. Every branch waits on the clock before looping, so out_ready gets one assignment per step.
  initial begin : receiver
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk_i);
      end
    end
  end

  // Any beat on the input, the output or the register port counts as progress.
  initial begin : watchdog
    int unsigned idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("watchdog: nothing moved for %0d cycles, %0d bytes still expected",
             StallLimit, pending);
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    psucf_cfg_t c;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset settings: both extremes of the manual voltage, every mode
    // frame, the unused operation codes, and a tick while periodic mode is off.
    send_beat(make_beat(OP_SET_PARAMS, 16'sd0, 16'h0000));
    send_beat(make_beat(OP_SET_PARAMS, 16'sd0, 16'hFFFF));
    send_beat(make_beat(OP_PC_ON, 16'sd0, 16'h0000));
    send_beat(make_beat(OP_PC_OFF, 16'sd0, 16'h0000));
    send_beat(make_beat(OP_SELF, 16'sd0, 16'h0000));
    for (int op = OP_UNUSED_FIRST; op <= OP_UNUSED_LAST; op++)
      send_beat(make_beat(3'(op), 16'sh7FFF, 16'hFFFF));
    send_beat(make_beat(OP_TICK, 16'sd500, 16'h0000));
    wait_drained();

    // Periodic mode with a threshold just over two ticks' worth: the first two ticks stay silent and
    // the third sends a frame with the accumulator remainder kept.
    apb_write(REG_UPDATE_PERIOD, 32'd8);
    apb_write(REG_PERIODIC_EN, 32'd1);
    cur_cfg.update_period_ms = 16'd8;
    cur_cfg.periodic_enable  = 1'b1;
    repeat (3) send_beat(make_beat(OP_TICK, 16'sd500, 16'h0000));
    wait_drained();

    // Every limit at its maximum, full signed sample range and a zero period, so each tick
    // sends a frame; samples at both ends and in the middle of the range.
    c = '{device_address: 8'hFF, current_limit: 16'hFFFF, voltage_limit: 16'hFFFF,
          power_limit: 16'hFFFF, update_period_ms: 16'd0, periodic_enable: 1'b1,
          sample_min: 16'sh8000, sample_max: 16'sh7FFF};
    load_config(c);
    send_beat(make_beat(OP_TICK, 16'sh8000, 16'h0000));
    send_beat(make_beat(OP_TICK, 16'sh7FFF, 16'h0000));
    send_beat(make_beat(OP_TICK, 16'sd0, 16'h0000));
    send_beat(make_beat(OP_SET_PARAMS, 16'sd0, 16'hA5A5));
    wait_drained();

    // Current and power limits at zero, a period shorter than one tick, and equal sample bounds.
    c = '{device_address: 8'h00, current_limit: 16'h0000, voltage_limit: 16'd1000,
          power_limit: 16'h0000, update_period_ms: 16'd1, periodic_enable: 1'b1,
          sample_min: 16'sd7, sample_max: 16'sd7};
    load_config(c);
    send_beat(make_beat(OP_TICK, 16'sd7, 16'h0000));
    wait_drained();

    // Narrow bounds: a sample below the minimum clamps to zero, a large one to full scale.
    apb_write(REG_SAMPLE_MIN, 32'd0);
    apb_write(REG_SAMPLE_MAX, 32'd100);
    cur_cfg.sample_min = 16'sd0;
    cur_cfg.sample_max = 16'sd100;
    send_beat(make_beat(OP_TICK, -16'sd50, 16'h0000));
    send_beat(make_beat(OP_TICK, 16'sh7FFF, 16'h0000));
    send_beat(make_beat(OP_TICK, 16'sd33, 16'h0000));
    wait_drained();

    // Random part: a fresh setting per phase. One phase starts with a long output hold-off
    // while beats keep coming, so the block backs up into its input; another pauses the
    // sender halfway until every byte is out. The last phase runs without any idling.
    for (int ph = 0; ph < RandomPhases; ph++) begin
      load_config(random_config());
      if (ph == RandomPhases - 1) quiet = 1'b1;
      if (ph == 2) hold_req = 1'b1;
      for (int n = 0; n < BeatsPerPhase; n++) begin
        if (ph == 3 && n == BeatsPerPhase / 2) wait_drained();
        send_beat(random_beat());
      end
      wait_drained();
    end

    $display("Run covered %0d input beats and %0d checked frame bytes,", beats_in, beats_out);
    $display("directed corner settings plus %0d random register settings.", RandomPhases);
    if (fail_count == 0 && pending == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d bytes never seen", fail_count, pending);
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

// File: filelist.f
+incdir+rtl
rtl/psucf_pkg.sv
rtl/psucf_cfg_regs.sv
rtl/psu_command_framer_top.sv
verif/psucf_frame_checker.sv
verif/tb_psu_command_framer_top.sv
